/* sv/tlc_pkg.sv */
package tlc_pkg;

  localparam int unsigned ValW     = 32;
  localparam int unsigned DurW     = 16;
  localparam int unsigned CntW     = 15;
  localparam int unsigned ProdW    = 48;
  localparam int unsigned DivSteps = ProdW / 2;
  localparam int unsigned StepW    = $clog2(DivSteps);
  localparam int unsigned CmdW     = 3;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK,
    CMD_PLAY,
    CMD_PAUSE,
    CMD_REVERSE,
    CMD_STOP,
    CMD_SKIP
  } cmd_e;

  typedef enum logic [1:0] {
    RS_STOP,
    RS_PLAY,
    RS_PAUSE,
    RS_REV
  } run_state_e;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_LOOP,
    EV_FINISH
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START,
    CFG_END,
    CFG_DUR,
    CFG_LIMIT,
    CFG_LOOP_MODE,
    CFG_FINISH_MODE
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV,
    CS_SUM,
    CS_WB
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic sum;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

/* sv/tlc_ctrl.sv */
module tlc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tlc_pkg::dp_status_t status_i,
  output tlc_pkg::dp_cmd_t    cmd_o
);
  import tlc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (in_valid_i) state_d = CS_MUL;
      CS_MUL:  state_d = CS_DIV;
      CS_DIV:  if (status_i.div_last) state_d = CS_SUM;
      CS_SUM:  state_d = CS_WB;
      CS_WB:   if (out_free) state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == CS_IDLE);
    cmd_o.load    = in_valid_i && (state_q == CS_IDLE);
    cmd_o.mul     = (state_q == CS_MUL);
    cmd_o.div     = (state_q == CS_DIV);
    cmd_o.sum     = (state_q == CS_SUM);
    cmd_o.commit  = (state_q == CS_WB) && out_free;
  end

  // hold the result beat until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/tlc_datapath.sv */
module tlc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlc_pkg::ValW-1:0]     cfg_data_i,
  input  tlc_pkg::dp_cmd_t             cmd_i,
  output tlc_pkg::dp_status_t          status_o,
  input  logic [tlc_pkg::CmdW-1:0]     in_cmd_i,
  input  logic [tlc_pkg::DurW-1:0]     in_elapsed_i,
  output logic [tlc_pkg::ValW-1:0]     value_o,
  output logic [tlc_pkg::ValW-1:0]     offset_o,
  output logic [1:0]                   run_state_o,
  output logic [1:0]                   prior_state_o,
  output logic [1:0]                   event_o,
  output logic [tlc_pkg::CntW-1:0]     passes_o
);
  import tlc_pkg::*;

  // configuration
  logic [ValW-1:0] start_q, end_q;
  logic [DurW-1:0] dur_q, lim_q;
  logic            loop_mode_q, finish_mode_q;

  // ramp state
  logic [DurW-1:0] pos_q;
  logic [ValW-1:0] level_q;
  run_state_e      mode_q, prior_q;
  logic [CntW-1:0] pass_q;

  // per-item work registers
  logic [CmdW-1:0]  cmd_q;
  logic [DurW-1:0]  tgt_q;
  logic [ProdW-1:0] nq_q;
  logic [DurW-1:0]  rem_q;
  logic             neg_q;
  logic [StepW-1:0] step_q;
  logic [ValW-1:0]  nv_q;

  // result registers
  logic [ValW-1:0] res_val_q, res_off_q;
  logic [1:0]      res_rs_q, res_ps_q, res_ev_q;
  logic [CntW-1:0] res_pass_q;

  logic [DurW-1:0] eff_dur, pos_clamp, tgt_d;
  logic [DurW:0]   pos_sum, eff17;
  logic [ValW:0]   diff, diff_abs;
  logic [ProdW-1:0] prod;
  logic [DurW:0]   r1, r1s, r2, r2s;
  logic            q1, q2;
  logic [ValW-1:0] quot;

  assign eff_dur   = (dur_q == '0) ? DurW'(1) : dur_q;
  assign eff17     = {1'b0, eff_dur};
  assign pos_clamp = (pos_q > eff_dur) ? eff_dur : pos_q;
  assign pos_sum   = {1'b0, pos_clamp} + {1'b0, in_elapsed_i};

  always_comb begin
    unique case (cmd_e'(in_cmd_i))
      CMD_TICK: begin
        if (mode_q == RS_PLAY) begin
          tgt_d = (pos_sum > eff17) ? eff_dur : pos_sum[DurW-1:0];
        end else begin
          tgt_d = (in_elapsed_i >= pos_clamp) ? '0 : pos_clamp - in_elapsed_i;
        end
      end
      CMD_SKIP: tgt_d = (in_elapsed_i > eff_dur) ? eff_dur : in_elapsed_i;
      default:  tgt_d = pos_clamp;
    endcase
  end

  assign diff     = {end_q[ValW-1], end_q} - {start_q[ValW-1], start_q};
  assign diff_abs = diff[ValW] ? (~diff + (ValW+1)'(1)) : diff;
  assign prod     = {{(ProdW-ValW){1'b0}}, diff_abs[ValW-1:0]}
                  * {{(ProdW-DurW){1'b0}}, tgt_q};

  // two restoring divide steps per cycle
  always_comb begin
    r1  = {rem_q, nq_q[ProdW-1]};
    q1  = (r1 >= eff17);
    r1s = q1 ? (r1 - eff17) : r1;
    r2  = {r1s[DurW-1:0], nq_q[ProdW-2]};
    q2  = (r2 >= eff17);
    r2s = q2 ? (r2 - eff17) : r2;
  end

  assign status_o.div_last = (step_q == StepW'(DivSteps - 1));
  assign quot = nq_q[ValW-1:0];

  // commit of one step
  logic [DurW-1:0] pos_n;
  logic [ValW-1:0] lvl_n, chg_n, loop_lvl;
  run_state_e      mode_n, prior_n;
  logic [CntW-1:0] pass_n;
  event_e          ev_n;
  logic            fin;
  logic [CntW:0]   pass_inc;

  always_comb begin
    pos_n    = pos_clamp;
    lvl_n    = level_q;
    chg_n    = '0;
    mode_n   = mode_q;
    prior_n  = prior_q;
    pass_n   = pass_q;
    ev_n     = EV_NONE;
    fin      = (mode_q == RS_PLAY) ? (tgt_q == eff_dur) : (tgt_q == '0);
    pass_inc = {1'b0, pass_q} + (CntW+1)'(1);
    loop_lvl = (mode_q == RS_PLAY) ? start_q : end_q;
    unique case (cmd_e'(cmd_q))
      CMD_TICK: begin
        if (mode_q == RS_PLAY || mode_q == RS_REV) begin
          lvl_n = nv_q;
          chg_n = nv_q - level_q;
          pos_n = tgt_q;
          if (fin) begin
            pass_n = pass_inc[CntW] ? {CntW{1'b1}} : pass_inc[CntW-1:0];
            if (lim_q[DurW-1] || (pass_inc <= {1'b0, lim_q[CntW-1:0]})) begin
              ev_n = EV_LOOP;
              if (!loop_mode_q) begin
                lvl_n = loop_lvl;
                chg_n = loop_lvl - nv_q;
                pos_n = (mode_q == RS_PLAY) ? '0 : eff_dur;
              end else begin
                prior_n = mode_q;
                mode_n  = (mode_q == RS_PLAY) ? RS_REV : RS_PLAY;
              end
            end else begin
              ev_n    = EV_FINISH;
              prior_n = mode_q;
              mode_n  = RS_STOP;
              pass_n  = '0;
              if (finish_mode_q) begin
                lvl_n = start_q;
                chg_n = start_q - nv_q;
                pos_n = '0;
              end
            end
          end
        end
      end
      CMD_PLAY: begin
        if (mode_q != RS_PLAY) begin
          prior_n = mode_q;
          mode_n  = RS_PLAY;
        end
      end
      CMD_PAUSE: begin
        if (mode_q != RS_PAUSE) begin
          prior_n = mode_q;
          mode_n  = RS_PAUSE;
        end
      end
      CMD_REVERSE: begin
        if (mode_q != RS_REV) begin
          prior_n = mode_q;
          mode_n  = RS_REV;
        end
      end
      CMD_STOP: begin
        if (mode_q != RS_STOP) begin
          prior_n = mode_q;
          mode_n  = RS_STOP;
        end
        pass_n = '0;
        if (finish_mode_q) begin
          lvl_n = start_q;
          chg_n = start_q - level_q;
          pos_n = '0;
        end
      end
      CMD_SKIP: begin
        lvl_n = nv_q;
        chg_n = nv_q - level_q;
        pos_n = tgt_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= '0;
      end_q         <= '0;
      dur_q         <= DurW'(1);
      lim_q         <= DurW'(1);
      loop_mode_q   <= 1'b0;
      finish_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START:       start_q       <= cfg_data_i;
        CFG_END:         end_q         <= cfg_data_i;
        CFG_DUR:         dur_q         <= cfg_data_i[DurW-1:0];
        CFG_LIMIT:       lim_q         <= cfg_data_i[DurW-1:0];
        CFG_LOOP_MODE:   loop_mode_q   <= cfg_data_i[0];
        CFG_FINISH_MODE: finish_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      level_q <= '0;
      mode_q  <= RS_STOP;
      prior_q <= RS_STOP;
      pass_q  <= '0;
      step_q  <= '0;
    end else begin
      if (cmd_i.mul) begin
        step_q <= '0;
      end else if (cmd_i.div) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.commit) begin
        pos_q   <= pos_n;
        level_q <= lvl_n;
        mode_q  <= mode_n;
        prior_q <= prior_n;
        pass_q  <= pass_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      tgt_q <= tgt_d;
    end
    if (cmd_i.mul) begin
      nq_q  <= prod;
      neg_q <= diff[ValW];
      rem_q <= '0;
    end else if (cmd_i.div) begin
      nq_q  <= {nq_q[ProdW-3:0], q1, q2};
      rem_q <= r2s[DurW-1:0];
    end
    if (cmd_i.sum) begin
      nv_q <= start_q + (neg_q ? (~quot + ValW'(1)) : quot);
    end
    if (cmd_i.commit) begin
      res_val_q  <= lvl_n;
      res_off_q  <= chg_n;
      res_rs_q   <= mode_n;
      res_ps_q   <= prior_n;
      res_ev_q   <= ev_n;
      res_pass_q <= pass_n;
    end
  end

  assign value_o       = res_val_q;
  assign offset_o      = res_off_q;
  assign run_state_o   = res_rs_q;
  assign prior_state_o = res_ps_q;
  assign event_o       = res_ev_q;
  assign passes_o      = res_pass_q;

endmodule

/* sv/tween_loop_controller_core.sv */
// Linear Q16.16 value ramp with repeat or ping-pong looping. Each input beat
// carries a command in tuser (tick, play, pause, reverse, stop, skip) and a
// time in tdata; every beat yields exactly one result beat with the value, the
// change made in that step, the run state, the prior state, a loop/finish
// event and the saturating pass count. After its input beat is accepted, an
// item passes through the 32x16 multiply, the divider that retires two
// quotient bits per cycle, forming of the new value and its commit; the block
// takes a new item only once it is through with the last one. The next item
// is taken right after the commit, even while the previous result still
// waits in the output register; a result that is still waiting holds the
// next commit and so the input. Write configuration only while idle.
module tween_loop_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tlc_pkg::ValW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // elapsed[15:0]
  input  logic [2:0]                  s_axis_tuser,  // command[2:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // value[31:0], offset[63:32], run_state[65:64], prior_state[67:66],
  // event_res[69:68], passes_done[84:70], zero[87:85]
  output logic [87:0]                 m_axis_tdata
);
  import tlc_pkg::*;

  dp_cmd_t         dp_cmd;
  dp_status_t      dp_status;
  logic [ValW-1:0] value, offset;
  logic [1:0]      run_state, prior_state, event_res;
  logic [CntW-1:0] passes_done;

  tlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  tlc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .in_cmd_i      (s_axis_tuser),
    .in_elapsed_i  (s_axis_tdata),
    .value_o       (value),
    .offset_o      (offset),
    .run_state_o   (run_state),
    .prior_state_o (prior_state),
    .event_o       (event_res),
    .passes_o      (passes_done)
  );

  assign m_axis_tdata = {3'b000, passes_done, event_res, prior_state, run_state,
                         offset, value};

endmodule

/* sv/tlc_checker.sv */
module tlc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [tlc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [tlc_pkg::ValW-1:0]    cfg_data_i,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [15:0]                 s_axis_tdata,
  input logic [2:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [87:0]                 m_axis_tdata
);
  import tlc_pkg::*;

  logic cfg_seen;
  assign cfg_seen = cfg_we_i && (cfg_idx_i != '0) && (cfg_data_i != '0)
                 && (s_axis_tdata != '0) && (s_axis_tuser != '0);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // finishing a run leaves the ramp stopped with a cleared count
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[69:68] == EV_FINISH)
      |-> (m_axis_tdata[65:64] == RS_STOP) && (m_axis_tdata[84:70] == '0))
    else $error("finish event without stop");

  // a new loop keeps the ramp running
  a_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[69:68] == EV_LOOP) && !cfg_seen
      |-> (m_axis_tdata[65:64] == RS_PLAY) || (m_axis_tdata[65:64] == RS_REV))
    else $error("loop event while not running");

endmodule

bind tween_loop_controller_core tlc_checker u_tlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_data_i    (cfg_data_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tlc_pkg::*;

  localparam int unsigned LATENCY     = 28;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int          PASS_MAX    = 32767;
  localparam logic [CmdW-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [31:0] LEVEL_MIN = 32'h8000_0000;
  localparam logic [31:0] LEVEL_MAX = 32'h7FFF_FFFF;
  localparam logic [15:0] LIMIT_ENDLESS = 16'hFFFF;

  // field order runs from the top bit down; value sits in the lowest bits
  typedef struct packed {
    logic [14:0] passes;
    logic [1:0]  ev;
    logic [1:0]  prior;
    logic [1:0]  state;
    logic [31:0] delta;
    logic [31:0] value;
  } ramp_result_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [ValW-1:0] cfg_data = '0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [15:0]     s_tdata = '0;
  logic [2:0]      s_tuser = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [87:0]     m_tdata;

  // ramp settings as the block holds them
  logic signed [31:0] ramp_start = '0;
  logic signed [31:0] ramp_end = '0;
  logic [15:0]        ramp_span = 16'd1;
  logic signed [15:0] loop_cap = 16'sd1;
  logic               pingpong_on = 1'b0;
  logic               rewind_on_stop = 1'b0;

  // ramp state
  logic [15:0] ramp_pos = '0;
  logic [31:0] ramp_level = '0;
  logic [31:0] ramp_delta = '0;
  run_state_e  ramp_state = RS_STOP;
  run_state_e  ramp_prev = RS_STOP;
  int          done_passes = 0;

  ramp_result_t expected_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  int mismatch_count = 0;
  int beats_sent = 0;
  int settings_used = 0;
  int loop_events = 0;
  int finish_events = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tween_loop_controller_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  function automatic int unsigned span_eff();
    return (ramp_span == 16'd0) ? 1 : int'(ramp_span);
  endfunction

  function automatic void move_to(int unsigned pos);
    longint base;
    longint diff;
    longint q;
    logic [31:0] nv;
    base = longint'(ramp_start);
    diff = longint'(ramp_end) - base;
    q = (diff * longint'(pos)) / longint'(span_eff());
    nv = 32'(base + q);
    ramp_pos = 16'(pos);
    ramp_delta = nv - ramp_level;
    ramp_level = nv;
  endfunction

  function automatic void change_state(run_state_e m);
    if (m != ramp_state) begin
      ramp_prev = ramp_state;
      ramp_state = m;
    end
  endfunction

  function automatic void stop_ramp();
    change_state(RS_STOP);
    done_passes = 0;
    if (rewind_on_stop) move_to(0);
  endfunction

  // Advance the ramp by one command and queue the result it must produce.
  function automatic void predict_step(logic [CmdW-1:0] cmd, logic [15:0] el);
    int unsigned d;
    int unsigned p;
    int n;
    logic fin;
    event_e ev;
    ramp_result_t r;
    d = span_eff();
    ev = EV_NONE;
    ramp_delta = '0;
    if (ramp_pos > d) ramp_pos = 16'(d);
    case (cmd)
      CMD_TICK: begin
        if (ramp_state == RS_PLAY || ramp_state == RS_REV) begin
          if (ramp_state == RS_PLAY) begin
            p = 32'(ramp_pos) + 32'(el);
            if (p > d) p = d;
            fin = (p == d);
          end else begin
            p = (el >= ramp_pos) ? 0 : 32'(ramp_pos) - 32'(el);
            fin = (p == 0);
          end
          move_to(p);
          if (fin) begin
            n = done_passes + 1;
            done_passes = (n > PASS_MAX) ? PASS_MAX : n;
            if (loop_cap < 0 || n <= int'(loop_cap)) begin
              if (!pingpong_on) move_to((ramp_state == RS_PLAY) ? 0 : d);
              else change_state((ramp_state == RS_PLAY) ? RS_REV : RS_PLAY);
              ev = EV_LOOP;
            end else begin
              ev = EV_FINISH;
              stop_ramp();
            end
          end
        end
      end
      CMD_PLAY:    change_state(RS_PLAY);
      CMD_PAUSE:   change_state(RS_PAUSE);
      CMD_REVERSE: change_state(RS_REV);
      CMD_STOP:    stop_ramp();
      CMD_SKIP:    move_to((el > d) ? d : el);
      default: ;
    endcase
    r.value  = ramp_level;
    r.delta  = ramp_delta;
    r.state  = ramp_state;
    r.prior  = ramp_prev;
    r.ev     = ev;
    r.passes = done_passes[14:0];
    expected_q.push_back(r);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      $error("%s: expected %h, got %h", name, exp, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result(logic [87:0] data);
    ramp_result_t got;
    ramp_result_t exp;
    got = ramp_result_t'(data[84:0]);
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected: value %h", got.value);
      mismatch_count++;
    end else begin
      exp = expected_q.pop_front();
      compare_field("value", exp.value, got.value);
      compare_field("offset", exp.delta, got.delta);
      compare_field("run_state", exp.state, got.state);
      compare_field("prior_state", exp.prior, got.prior);
      compare_field("event_res", exp.ev, got.ev);
      compare_field("passes_done", exp.passes, got.passes);
      if (exp.ev == EV_LOOP) loop_events++;
      if (exp.ev == EV_FINISH) finish_events++;
    end
  endfunction

  // result side: check each beat, stall at random or through a long hold-off
  always @(posedge clk) begin
    if (rst_n && m_tvalid === 1'b1 && m_tready) check_result(m_tdata);
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Valid stays high after a beat so the next beat can follow without a gap.
  task automatic send_beat(input logic [CmdW-1:0] cmd, input logic [15:0] el);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= el;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_step(cmd, el);
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_ramp(input logic [31:0] start_v, input logic [31:0] end_v,
                              input logic [15:0] span, input logic [15:0] cap,
                              input logic pingpong, input logic rewind);
    put_reg(CFG_START, start_v);
    put_reg(CFG_END, end_v);
    put_reg(CFG_DUR, {16'd0, span});
    put_reg(CFG_LIMIT, {16'd0, cap});
    put_reg(CFG_LOOP_MODE, {31'd0, pingpong});
    put_reg(CFG_FINISH_MODE, {31'd0, rewind});
    cfg_we <= 1'b0;
    ramp_start = start_v;
    ramp_end = end_v;
    ramp_span = span;
    loop_cap = cap;
    pingpong_on = pingpong;
    rewind_on_stop = rewind;
    settings_used++;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(9))
      0: return LEVEL_MIN;
      1: return LEVEL_MAX;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_span();
    case ($urandom_range(19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] pick_cap();
    case ($urandom_range(19))
      0, 1, 2: return LIMIT_ENDLESS;
      3: return 16'd32767;
      4: return 16'd0;
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_tick(int unsigned d);
    if ($urandom_range(99) < 12) return 16'($urandom);
    return 16'($urandom_range(0, d / 3 + 1));
  endfunction

  // mostly ticks while running, with state changes, skips and stray codes mixed in
  task automatic send_random_beat();
    int unsigned r;
    int unsigned d;
    d = span_eff();
    r = $urandom_range(99);
    if (r < 62) send_beat(CMD_TICK, pick_tick(d));
    else if (r < 70) send_beat(CMD_PLAY, 16'($urandom));
    else if (r < 76) send_beat(CMD_REVERSE, 16'($urandom));
    else if (r < 81) send_beat(CMD_PAUSE, 16'($urandom));
    else if (r < 84) send_beat(CMD_STOP, 16'($urandom));
    else if (r < 93) send_beat(CMD_SKIP, 16'($urandom_range(0, d + d / 8 + 1)));
    else send_beat(3'($urandom_range(7)), 16'($urandom));
  endtask

  task automatic test_directed_commands();
    program_ramp(LEVEL_MIN, LEVEL_MAX, 16'd100, 16'd1, 1'b0, 1'b0);
    send_beat(CMD_TICK, 16'hFFFF);    // stopped: ignored
    send_beat(CMD_SPARE_LO, 16'h0000);
    send_beat(CMD_SPARE_HI, 16'hFFFF);
    send_beat(CMD_PLAY, 16'h0000);
    send_beat(CMD_PLAY, 16'h5A5A);    // same state: prior kept
    send_beat(CMD_TICK, 16'd30);
    send_beat(CMD_PAUSE, 16'h0000);
    send_beat(CMD_TICK, 16'd10);      // paused: ignored
    send_beat(CMD_REVERSE, 16'h0000);
    send_beat(CMD_TICK, 16'hFFFF);    // back at zero: restart from the end
    send_beat(CMD_TICK, 16'hFFFF);    // limit passed: finish and hold
    send_beat(CMD_SKIP, 16'hFFFF);    // clamp to duration
    send_beat(CMD_SKIP, 16'h0000);
  endtask

  task automatic test_pingpong_finish();
    wait_drained();
    program_ramp(LEVEL_MAX, LEVEL_MIN, 16'd0, 16'd2, 1'b1, 1'b1);
    send_beat(CMD_PLAY, 16'h0000);
    send_beat(CMD_TICK, 16'd1);
    send_beat(CMD_TICK, 16'd1);
    send_beat(CMD_TICK, 16'hFFFF);
    send_beat(CMD_SKIP, 16'd1);
    send_beat(CMD_STOP, 16'h0000);    // rewind to start
  endtask

  task automatic test_shrunk_duration();
    wait_drained();
    program_ramp(32'h0000_0000, 32'h0064_0000, 16'd1000, LIMIT_ENDLESS, 1'b0, 1'b0);
    send_beat(CMD_PLAY, 16'h0000);
    send_beat(CMD_SKIP, 16'd900);
    wait_drained();
    program_ramp(32'h0000_0000, 32'h0064_0000, 16'd10, LIMIT_ENDLESS, 1'b0, 1'b0);
    send_beat(CMD_TICK, 16'd0);       // position clamps to the new end and loops back to the start
    send_beat(CMD_STOP, 16'h0000);
  endtask

  task automatic test_random_ramps();
    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      if (ph == 0)
        program_ramp(LEVEL_MIN, LEVEL_MAX, 16'hFFFF, 16'd32767, 1'b1, 1'b1);
      else if (ph == 1)
        program_ramp(LEVEL_MAX, LEVEL_MIN, 16'd1, LIMIT_ENDLESS, 1'b0, 1'b0);
      else
        program_ramp(pick_level(), pick_level(), pick_span(), pick_cap(),
                     1'($urandom), 1'($urandom));
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(83, 0);
        2: set_idling(0, 83);
        default: set_idling(25, 25);
      endcase
      send_beat($urandom_range(1) ? CMD_PLAY : CMD_REVERSE, 16'($urandom));
      repeat (114) send_random_beat();
    end
  endtask

  task automatic test_output_holdoff();
    wait_drained();
    set_idling(0, 0);
    program_ramp(32'hFFF0_0000, 32'h0010_0000, 16'd20, LIMIT_ENDLESS, 1'b1, 1'b0);
    send_beat(CMD_PLAY, 16'h0000);
    hold_toggle <= ~hold_toggle;
    repeat (40) send_beat(CMD_TICK, 16'($urandom_range(0, 12)));
  endtask

  // endless looping keeps counting passes; a limit below the count then finishes
  task automatic test_pass_count();
    wait_drained();
    set_idling(0, 0);
    program_ramp(32'h0001_0000, 32'hFFFF_0000, 16'd1, LIMIT_ENDLESS, 1'b0, 1'b0);
    send_beat(CMD_PLAY, 16'h0000);
    repeat (40) send_beat(CMD_TICK, 16'($urandom_range(1, 65535)));
    wait_drained();
    program_ramp(32'h0001_0000, 32'hFFFF_0000, 16'd1, 16'd3, 1'b0, 1'b0);
    send_beat(CMD_TICK, 16'd1);
    send_beat(CMD_STOP, 16'h0000);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_pingpong_finish();
    test_shrunk_duration();
    test_random_ramps();
    test_output_holdoff();
    test_pass_count();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    $display("Covered %0d command beats over %0d register settings, four idling mixes,",
             beats_sent, settings_used);
    $display("a long output hold-off and a pass count run past its limit; %0d loops, %0d finishes.",
             loop_events, finish_events);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
